### src/aabb_xf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AABB affine transform package
// Shared types and constants for the box transform block.
// ---------------------------------------------------------------------------
package aabb_xf_pkg;

   localparam int COORD_W   = 20;
   localparam int COEF_W    = 16;
   localparam int COEF_FRAC = 12;
   localparam int AXES      = 3;
   localparam int PROD_W    = COORD_W + COEF_W;
   localparam int TERM_W    = PROD_W - COEF_FRAC;
   localparam int SUM_W     = TERM_W + 2;
   localparam int ROW_W     = AXES * COEF_W;
   localparam int TRANS_W   = AXES * COORD_W;
   localparam int CSR_W     = TRANS_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic [1:0]                csr_index_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_COEF_FROM_X = 2'd0;
   localparam csr_index_type CSR_COEF_FROM_Y = 2'd1;
   localparam csr_index_type CSR_COEF_FROM_Z = 2'd2;
   localparam csr_index_type CSR_TRANSLATION = 2'd3;

   // Reset map is the identity: 1.0 in Q4.12 on the diagonal.
   localparam logic [ROW_W-1:0]   COEF_FROM_X_RST = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0]   COEF_FROM_Y_RST = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0]   COEF_FROM_Z_RST = 48'h1000_0000_0000;
   localparam logic [TRANS_W-1:0] TRANSLATION_RST = '0;

   typedef struct packed {
      coord_type in_min_x;
      coord_type in_min_y;
      coord_type in_min_z;
      coord_type in_max_x;
      coord_type in_max_y;
      coord_type in_max_z;
   } req_type;

   typedef struct packed {
      coord_type out_min_x;
      coord_type out_min_y;
      coord_type out_min_z;
      coord_type out_max_x;
      coord_type out_max_y;
      coord_type out_max_z;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0]   coef_from_x;
      logic [ROW_W-1:0]   coef_from_y;
      logic [ROW_W-1:0]   coef_from_z;
      logic [TRANS_W-1:0] translation;
   } cfg_type;

endpackage

### src/aabb_xf_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AABB transform configuration registers
// Holds the coefficient rows and the translation, written by index.
// ---------------------------------------------------------------------------
module aabb_xf_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  aabb_xf_pkg::csr_index_type csr_index,
   input  logic [aabb_xf_pkg::CSR_W-1:0] csr_wdata,
   output aabb_xf_pkg::cfg_type       cfg
);
   import aabb_xf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COEF_FROM_X: cfg_in.coef_from_x = csr_wdata[ROW_W-1:0];
            CSR_COEF_FROM_Y: cfg_in.coef_from_y = csr_wdata[ROW_W-1:0];
            CSR_COEF_FROM_Z: cfg_in.coef_from_z = csr_wdata[ROW_W-1:0];
            CSR_TRANSLATION: cfg_in.translation = csr_wdata[TRANS_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_from_x <= COEF_FROM_X_RST;
         cfg_ff.coef_from_y <= COEF_FROM_Y_RST;
         cfg_ff.coef_from_z <= COEF_FROM_Z_RST;
         cfg_ff.translation <= TRANSLATION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/aabb_xf_axis.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AABB transform, one output axis
// Sign-selected products, floor shift, four-term sum and saturation.
// ---------------------------------------------------------------------------
module aabb_xf_axis (
   input  aabb_xf_pkg::coord_type [2:0] lo,
   input  aabb_xf_pkg::coord_type [2:0] hi,
   input  aabb_xf_pkg::coef_type  [2:0] coef,
   input  aabb_xf_pkg::coord_type       trans,
   output aabb_xf_pkg::coord_type       out_min,
   output aabb_xf_pkg::coord_type       out_max
);
   import aabb_xf_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (COORD_W - 1));

   logic signed [PROD_W-1:0] prod_min [AXES];
   logic signed [PROD_W-1:0] prod_max [AXES];
   logic signed [TERM_W-1:0] term_min [AXES];
   logic signed [TERM_W-1:0] term_max [AXES];
   logic signed [SUM_W-1:0]  sum_min;
   logic signed [SUM_W-1:0]  sum_max;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         // A positive coefficient keeps the order; zero or negative swaps it.
         if (!coef[i][COEF_W-1] && (coef[i] != '0)) begin
            prod_min[i] = lo[i] * coef[i];
            prod_max[i] = hi[i] * coef[i];
         end else begin
            prod_min[i] = hi[i] * coef[i];
            prod_max[i] = lo[i] * coef[i];
         end
         // Dropping the low bits of a two's complement value rounds down.
         term_min[i] = prod_min[i][PROD_W-1:COEF_FRAC];
         term_max[i] = prod_max[i][PROD_W-1:COEF_FRAC];
      end
      sum_min = SUM_W'(trans) + SUM_W'(term_min[0]) + SUM_W'(term_min[1])
              + SUM_W'(term_min[2]);
      sum_max = SUM_W'(trans) + SUM_W'(term_max[0]) + SUM_W'(term_max[1])
              + SUM_W'(term_max[2]);
   end

   always_comb begin
      if (sum_min > SAT_HI) begin
         out_min = SAT_HI[COORD_W-1:0];
      end else if (sum_min < SAT_LO) begin
         out_min = SAT_LO[COORD_W-1:0];
      end else begin
         out_min = sum_min[COORD_W-1:0];
      end
      if (sum_max > SAT_HI) begin
         out_max = SAT_HI[COORD_W-1:0];
      end else if (sum_max < SAT_LO) begin
         out_max = SAT_LO[COORD_W-1:0];
      end else begin
         out_max = sum_max[COORD_W-1:0];
      end
   end

endmodule

### src/aabb_affine_transform.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AABB affine transform
// Tight axis-aligned bound of a box under a configured affine map.
// ---------------------------------------------------------------------------
// An accepted box is held in the input register, and its result is loaded
// into the result register after the product/sum logic.
// Throughput: one box per cycle while rsp_stall is low; the result register
// lets a new box enter while the previous result is still waiting on the output.
// Reset clears both valid flags and loads the identity map.
module aabb_affine_transform (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  aabb_xf_pkg::req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output aabb_xf_pkg::rsp_type          rsp_data,
   input  logic                          csr_we,
   input  aabb_xf_pkg::csr_index_type    csr_index,
   input  logic [aabb_xf_pkg::CSR_W-1:0] csr_wdata
);
   import aabb_xf_pkg::*;

   cfg_type   cfg;
   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      out_ready;
   logic      s1_ready;
   logic      req_xfer;
   coord_type [2:0] lo;
   coord_type [2:0] hi;
   coord_type [2:0] res_min;
   coord_type [2:0] res_max;

   aabb_xf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign lo = {s1_data_ff.in_min_z, s1_data_ff.in_min_y, s1_data_ff.in_min_x};
   assign hi = {s1_data_ff.in_max_z, s1_data_ff.in_max_y, s1_data_ff.in_max_x};

   for (genvar j = 0; j < AXES; j++) begin : g_axis
      coef_type [2:0] coef_col;
      coord_type      trans_j;

      assign coef_col = {cfg.coef_from_z[COEF_W*j +: COEF_W],
                         cfg.coef_from_y[COEF_W*j +: COEF_W],
                         cfg.coef_from_x[COEF_W*j +: COEF_W]};
      assign trans_j  = cfg.translation[COORD_W*j +: COORD_W];

      aabb_xf_axis u_axis (
         .lo      (lo),
         .hi      (hi),
         .coef    (coef_col),
         .trans   (trans_j),
         .out_min (res_min[j]),
         .out_max (res_max[j])
      );
   end

   // The result register takes a new value when it is empty or being drained.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;
   assign req_xfer  = req_valid && s1_ready;

   assign s1_valid_in  = s1_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;

   always_comb begin
      rsp_data_in.out_min_x = res_min[0];
      rsp_data_in.out_min_y = res_min[1];
      rsp_data_in.out_min_z = res_min[2];
      rsp_data_in.out_max_x = res_max[0];
      rsp_data_in.out_max_y = res_max[1];
      rsp_data_in.out_max_z = res_max[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (out_ready && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stalling the input only happens when the input register holds a box.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty input register");

   // An accepted box is in the input register on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted box was not captured");

   // A box moving out of the input register produces a valid result.
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_ready) |=> rsp_valid_ff)
      else $error("box left the input register without a result");

   // An ordered input box gives an ordered output box.
   a_order_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_ready && (lo[0] <= hi[0]) && (lo[1] <= hi[1])
       && (lo[2] <= hi[2]))
      |=> ((rsp_data_ff.out_min_x <= rsp_data_ff.out_max_x)
        && (rsp_data_ff.out_min_y <= rsp_data_ff.out_max_y)
        && (rsp_data_ff.out_min_z <= rsp_data_ff.out_max_z)))
      else $error("transformed box lost min/max order");

endmodule
